/* hdl/lzwc_pkg.sv */
// shared constants and types of the lzw byte compressor
package lzwc_pkg;

  localparam int MAX_CODE_BITS = 16;
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int NF_W          = MAX_CODE_BITS + 1;
  localparam int DICT_DEPTH    = 1 << MAX_CODE_BITS;
  localparam int EPOCH_W       = 8;
  localparam int START_WIDTH   = 9;
  localparam int FIRST_FREE    = 256;
  localparam int CAP_RESET     = 65536;
  localparam int MIN_CAP       = 4;
  localparam int ACC_W         = 24;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_result;
    logic        error_flag;
    logic [31:0] total_bytes;
  } out_item_t;

  // link words carry the dictionary epoch they were written in
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    code_t              link;
  } child_word_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [7:0]         byte_val;
    code_t              sib;
  } node_word_t;

endpackage

/* hdl/lzwc_ram.sv */
// generic simple dual-port ram with registered read
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lzw_byte_compressor_top.sv */
// lzw byte compressor: sequencer, dictionary rams and code packer
//
// One input byte is taken at a time; in_stall is high while it is worked on.
// In order, the first byte of a buffer passes the end check and the flush.
// A byte that extends the current string passes the child read, one node
// read per node in the sibling walk, the end check and the flush. A byte that
// ends a string passes the child read, the node reads, the code load, packing
// of each output byte, two link write steps, the update, the end check and
// the flush, with one link write step fewer when the current code had no
// children yet. The end item swaps the flush for the code load, packing, the
// pad byte and the closing transfer. A stalled output holds the sequencer
// wherever a byte waits for the output register. After reset, and after
// every 256th dictionary clear, all 65536 words of the link rams are swept
// to zero, during which no byte is taken; other clears only advance an epoch
// tag kept with each link word.
module lzw_byte_compressor_top import lzwc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SWEEP  = 4'd1;
  localparam logic [3:0] S_CRD    = 4'd2;
  localparam logic [3:0] S_NRD    = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_PUT    = 4'd5;
  localparam logic [3:0] S_WR1    = 4'd6;
  localparam logic [3:0] S_WR2    = 4'd7;
  localparam logic [3:0] S_UPD    = 4'd8;
  localparam logic [3:0] S_ENDCHK = 4'd9;
  localparam logic [3:0] S_PAD    = 4'd10;
  localparam logic [3:0] S_LAST   = 4'd11;
  localparam logic [3:0] S_FLUSH  = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               end_r, end_nxt;
  code_t              cur_r, cur_nxt;
  logic               have_r, have_nxt;
  code_t              first_r, first_nxt;
  code_t              node_r, node_nxt;
  logic [7:0]         nbyte_r, nbyte_nxt;
  logic [NF_W-1:0]    nf_r, nf_nxt;
  logic [4:0]         width_r, width_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [4:0]         pend_r, pend_nxt;
  logic [31:0]        bw_r, bw_nxt;
  logic [31:0]        cap_r;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  code_t              sweep_r, sweep_nxt;
  logic               ret_end_r, ret_end_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  logic [7:0]         hold_byte_r, hold_byte_nxt;
  logic [31:0]        hold_total_r, hold_total_nxt;
  logic               out_valid_r;
  out_item_t          out_r;
  logic               out_load;
  out_item_t          out_nxt;

  logic               c_we;
  code_t              c_waddr, c_raddr;
  child_word_t        c_wdata, c_q;
  logic               n_we;
  code_t              n_waddr, n_raddr;
  node_word_t         n_wdata, n_q;

  code_t              child_link;
  code_t              sib_link;
  logic               slot_free;
  logic               in_xfer;

  lzwc_ram #(.WIDTH($bits(child_word_t)), .DEPTH(DICT_DEPTH)) u_child_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_q)
  );

  lzwc_ram #(.WIDTH($bits(node_word_t)), .DEPTH(DICT_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || !out_stall;

  // stale epoch reads as no link
  assign child_link = (c_q.tag == epoch_r) ? c_q.link : '0;
  assign sib_link   = (n_q.tag == epoch_r) ? n_q.sib : '0;

  always_comb begin
    logic                can_emit;
    logic                emit_req;
    logic                step_ok;
    logic [7:0]          eb;
    logic [4:0]          pend_dec;
    logic [ACC_W+15:0]   wide;
    logic [NF_W-1:0]     nf_inc;
    logic [ACC_W-1:0]    pad_sh;

    state_nxt      = state_r;
    byte_nxt       = byte_r;
    end_nxt        = end_r;
    cur_nxt        = cur_r;
    have_nxt       = have_r;
    first_nxt      = first_r;
    node_nxt       = node_r;
    nbyte_nxt      = nbyte_r;
    nf_nxt         = nf_r;
    width_nxt      = width_r;
    acc_nxt        = acc_r;
    pend_nxt       = pend_r;
    bw_nxt         = bw_r;
    epoch_nxt      = epoch_r;
    sweep_nxt      = sweep_r;
    ret_end_nxt    = ret_end_r;
    hold_valid_nxt = hold_valid_r;
    hold_byte_nxt  = hold_byte_r;
    hold_total_nxt = hold_total_r;
    out_load       = 1'b0;
    out_nxt        = out_r;

    c_we    = 1'b0;
    c_waddr = cur_r;
    c_wdata = '0;
    c_raddr = cur_r;
    n_we    = 1'b0;
    n_waddr = nf_r[CODE_W-1:0];
    n_wdata = '0;
    n_raddr = child_link;

    can_emit = (cap_r > 32'(MIN_CAP)) && (bw_r < cap_r);
    emit_req = 1'b0;
    step_ok  = 1'b0;
    pend_dec = pend_r - 5'd8;
    eb       = 8'(acc_r >> pend_dec);
    pad_sh   = acc_r << (5'd8 - pend_r);
    wide     = {16'b0, acc_r} << width_r;
    nf_inc   = nf_r + NF_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          byte_nxt = in_data.in_byte;
          end_nxt  = in_data.end_of_data;
          if (!have_r) begin
            // start of buffer
            epoch_nxt = epoch_r + EPOCH_W'(1);
            nf_nxt    = NF_W'(FIRST_FREE);
            width_nxt = 5'(START_WIDTH);
            acc_nxt   = '0;
            pend_nxt  = '0;
            bw_nxt    = '0;
            cur_nxt   = CODE_W'(in_data.in_byte);
            have_nxt  = 1'b1;
            sweep_nxt = '0;
            state_nxt = (epoch_nxt == '0) ? S_SWEEP : S_ENDCHK;
          end else begin
            state_nxt = S_CRD;
          end
        end
      end
      S_SWEEP: begin
        c_we      = 1'b1;
        c_waddr   = sweep_r;
        n_we      = 1'b1;
        n_waddr   = sweep_r;
        sweep_nxt = sweep_r + CODE_W'(1);
        if (sweep_r == '1) begin
          state_nxt = S_ENDCHK;
        end
      end
      S_CRD: begin
        first_nxt = child_link;
        node_nxt  = child_link;
        n_raddr   = child_link;
        if (child_link == '0) begin
          ret_end_nxt = 1'b0;
          state_nxt   = S_LOAD;
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        nbyte_nxt = n_q.byte_val;
        n_raddr   = sib_link;
        if (n_q.byte_val == byte_r) begin
          cur_nxt   = node_r;
          state_nxt = S_ENDCHK;
        end else if (sib_link != '0) begin
          node_nxt = sib_link;
        end else begin
          ret_end_nxt = 1'b0;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        acc_nxt   = wide[ACC_W-1:0] | ACC_W'(cur_r);
        pend_nxt  = pend_r + width_r;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (pend_r >= 5'd8) begin
          emit_req = 1'b1;
          if (step_ok) begin
            pend_nxt = pend_dec;
            acc_nxt  = acc_r & ~({ACC_W{1'b1}} << pend_dec);
          end
        end else begin
          state_nxt = ret_end_r ? S_PAD : S_WR1;
        end
      end
      S_WR1: begin
        n_we    = 1'b1;
        n_waddr = nf_r[CODE_W-1:0];
        n_wdata = '{tag: epoch_r, byte_val: byte_r, sib: '0};
        if (first_r == '0) begin
          c_we      = 1'b1;
          c_waddr   = cur_r;
          c_wdata   = '{tag: epoch_r, link: nf_r[CODE_W-1:0]};
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_WR2;
        end
      end
      S_WR2: begin
        n_we      = 1'b1;
        n_waddr   = node_r;
        n_wdata   = '{tag: epoch_r, byte_val: nbyte_r, sib: nf_r[CODE_W-1:0]};
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cur_nxt = CODE_W'(byte_r);
        if (nf_inc == (NF_W'(1) << width_r)) begin
          width_nxt = width_r + 5'd1;
        end
        if (nf_inc == NF_W'(DICT_DEPTH)) begin
          // dictionary full
          nf_nxt    = NF_W'(FIRST_FREE);
          width_nxt = 5'(START_WIDTH);
          epoch_nxt = epoch_r + EPOCH_W'(1);
          sweep_nxt = '0;
          state_nxt = (epoch_nxt == '0) ? S_SWEEP : S_ENDCHK;
        end else begin
          nf_nxt    = nf_inc;
          state_nxt = S_ENDCHK;
        end
      end
      S_ENDCHK: begin
        if (end_r) begin
          ret_end_nxt = 1'b1;
          state_nxt   = S_LOAD;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_PAD: begin
        if (pend_r != '0) begin
          emit_req = 1'b1;
          eb       = pad_sh[7:0];
          if (step_ok) begin
            pend_nxt  = '0;
            state_nxt = S_LAST;
          end
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (hold_valid_r) begin
            out_nxt = '{out_byte: hold_byte_r, byte_valid: 1'b1, last_result: 1'b1,
                        error_flag: 1'b0, total_bytes: hold_total_r};
          end else begin
            // an error result reports no bytes
            out_nxt = '{out_byte: 8'd0, byte_valid: 1'b0, last_result: 1'b1,
                        error_flag: !(cap_r > 32'(MIN_CAP)),
                        total_bytes: (cap_r > 32'(MIN_CAP)) ? bw_r : 32'd0};
          end
          hold_valid_nxt = 1'b0;
          have_nxt       = 1'b0;
          end_nxt        = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_load       = 1'b1;
          out_nxt        = '{out_byte: hold_byte_r, byte_valid: 1'b1, last_result: 1'b0,
                             error_flag: 1'b0, total_bytes: hold_total_r};
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // one byte is held back so the last one of a buffer can be marked
    if (emit_req) begin
      if (!can_emit) begin
        step_ok = 1'b1;
      end else if (!hold_valid_r || slot_free) begin
        step_ok = 1'b1;
        if (hold_valid_r) begin
          out_load = 1'b1;
          out_nxt  = '{out_byte: hold_byte_r, byte_valid: 1'b1, last_result: 1'b0,
                       error_flag: 1'b0, total_bytes: hold_total_r};
        end
        hold_valid_nxt = 1'b1;
        hold_byte_nxt  = eb;
        hold_total_nxt = bw_r + 32'd1;
        bw_nxt         = bw_r + 32'd1;
      end
      if (step_ok) begin
        if (state_r == S_PUT) begin
          pend_nxt = pend_dec;
          acc_nxt  = acc_r & ~({ACC_W{1'b1}} << pend_dec);
        end else begin
          pend_nxt  = '0;
          state_nxt = S_LAST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      end_r        <= 1'b0;
      have_r       <= 1'b0;
      cur_r        <= '0;
      nf_r         <= NF_W'(FIRST_FREE);
      width_r      <= 5'(START_WIDTH);
      acc_r        <= '0;
      pend_r       <= '0;
      bw_r         <= '0;
      cap_r        <= 32'(CAP_RESET);
      epoch_r      <= '0;
      sweep_r      <= '0;
      ret_end_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      end_r        <= end_nxt;
      have_r       <= have_nxt;
      cur_r        <= cur_nxt;
      nf_r         <= nf_nxt;
      width_r      <= width_nxt;
      acc_r        <= acc_nxt;
      pend_r       <= pend_nxt;
      bw_r         <= bw_nxt;
      epoch_r      <= epoch_nxt;
      sweep_r      <= sweep_nxt;
      ret_end_r    <= ret_end_nxt;
      hold_valid_r <= hold_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    first_r      <= first_nxt;
    node_r       <= node_nxt;
    nbyte_r      <= nbyte_nxt;
    hold_byte_r  <= hold_byte_nxt;
    hold_total_r <= hold_total_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_valid_r)
    else $error("held byte left over after an item");

  a_idle_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pend_r < 5'd8))
    else $error("whole byte left in the bit packer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> slot_free)
    else $error("output register loaded while a transfer is pending");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (width_r >= 5'(START_WIDTH) && width_r <= 5'(MAX_CODE_BITS)))
    else $error("code width out of range");

endmodule
